/* sv/kce_pkg.sv */
// Package for the keypad code entry controller.
// Field widths, key and slot codes, register indexes and reset values.
// No dependencies.
package kce_pkg;

  localparam int KEY_W      = 12;
  localparam int NIB_W      = 4;
  localparam int PASS_W     = 16;
  localparam int ELAPSED_W  = 24;
  localparam int STEP_W     = 20;
  localparam int HALF_W     = 16;
  localparam int AGE_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CODE_W     = 15;
  localparam int CODE_ACC_W = 14;
  localparam int DIV_CW     = $clog2(ELAPSED_W);

  typedef logic [NIB_W-1:0] nibble_t;

  localparam nibble_t NO_KEY     = 4'd15;
  localparam nibble_t EMPTY_SLOT = 4'd15;
  localparam nibble_t KEY_ZERO   = 4'd0;
  localparam nibble_t KEY_CLEAR  = 4'd11;
  localparam nibble_t KEY_OK     = 4'd12;
  localparam nibble_t DIGIT_LIM  = 4'd10;

  localparam logic [CFG_IDX_W-1:0] REG_PASSCODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLR_HALF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OK_HALF   = 3'd4;

  localparam logic [1:0] ST_WAIT     = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;

  localparam logic [1:0] COLOR_GREEN  = 2'd0;
  localparam logic [1:0] COLOR_YELLOW = 2'd1;
  localparam logic [1:0] COLOR_RED    = 2'd2;

  localparam logic [1:0] KS_NONE  = 2'd0;
  localparam logic [1:0] KS_CLICK = 2'd1;
  localparam logic [1:0] KS_WRONG = 2'd2;
  localparam logic [1:0] KS_CLEAR = 2'd3;

  localparam logic [1:0] BS_NONE   = 2'd0;
  localparam logic [1:0] BS_RED    = 2'd1;
  localparam logic [1:0] BS_NORMAL = 2'd2;

  localparam logic [CODE_W-1:0]     CODE_NONE = 15'h7FFF;
  localparam logic [CODE_ACC_W-1:0] CODE_SAT  = 14'h3FFF;

  localparam logic [PASS_W-1:0]    RST_PASSCODE = 16'd0;
  localparam logic [ELAPSED_W-1:0] RST_TIMEOUT  = 24'd60000;
  localparam logic [STEP_W-1:0]    RST_STEP     = 20'd2500;
  localparam logic [HALF_W-1:0]    RST_HALF     = 16'd250;

endpackage

/* sv/kce_if.sv */
// Valid/ready channel interfaces of the keypad code entry controller.
// Depends on kce_pkg for payload widths.
interface kce_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [kce_pkg::KEY_W-1:0]   key_lines;
  modport source (output valid, kind, key_lines, input ready);
  modport sink   (input valid, kind, key_lines, output ready);
endinterface

interface kce_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic [4:0]                         bar_lights;
  logic [1:0]                         bar_color;
  logic [15:0]                        shown_digits;
  logic [3:0]                         correct_mask;
  logic [3:0]                         wrong_mask;
  logic                               clear_lamp;
  logic                               ok_lamp;
  logic [1:0]                         key_sound;
  logic [1:0]                         bar_sound;
  logic signed [kce_pkg::CODE_W-1:0]  entered_code;
  modport source (output valid, status, bar_lights, bar_color, shown_digits, correct_mask,
                  wrong_mask, clear_lamp, ok_lamp, key_sound, bar_sound, entered_code,
                  input ready);
  modport sink   (input valid, status, bar_lights, bar_color, shown_digits, correct_mask,
                  wrong_mask, clear_lamp, ok_lamp, key_sound, bar_sound, entered_code,
                  output ready);
endinterface

interface kce_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [kce_pkg::CFG_IDX_W-1:0]    index;
  logic [kce_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/keypad_code_entry_controller.sv */
// Keypad code entry controller: slots, session timer, countdown bar, lamps.
// Depends on kce_pkg and the channel interfaces in kce_if.sv.
//
//   port      dir   beat
//   in_beat   sink  one sample (kind 0) or session restart (kind 1)
//   out_beat  src   one result per sample; restart gives none
//   cfg_beat  sink  register write, index and data
//
// Input stage then result register; one beat per cycle when not held off.
// Bar segment count is kept as a running quotient of elapsed time.
// A write to bar_step_ms re-divides elapsed time bit-serially, input held
// off meanwhile. No clearing pass after reset.
// Result register stall holds the input stage; cfg_beat is always ready.
module keypad_code_entry_controller #(
  parameter int CODE_DIGITS  = 4,
  parameter int BAR_SEGMENTS = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  kce_in_if.sink       in_beat,
  kce_out_if.source    out_beat,
  kce_cfg_if.sink      cfg_beat
);

  localparam int LW     = $clog2(BAR_SEGMENTS + 1);
  localparam int SLOT_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int EW     = kce_pkg::ELAPSED_W;
  localparam int SW     = kce_pkg::STEP_W;
  localparam int AW     = kce_pkg::AGE_W;
  localparam int CODE_ACC_W_L = kce_pkg::CODE_ACC_W;

  // configuration
  logic [kce_pkg::PASS_W-1:0] pass_r;
  logic [EW-1:0]              timeout_r;
  logic [SW-1:0]              step_r;
  logic [kce_pkg::HALF_W-1:0] clr_half_r;
  logic [kce_pkg::HALF_W-1:0] ok_half_r;

  // session state
  kce_pkg::nibble_t  slots_r [CODE_DIGITS];
  kce_pkg::nibble_t  slots_nxt [CODE_DIGITS];
  logic [1:0]        status_r, status_nxt;
  logic [EW-1:0]     elapsed_r, elapsed_nxt;
  logic [SW-1:0]     rem_r, rem_nxt;
  logic [LW-1:0]     q_r, q_nxt;
  logic [LW-1:0]     seg_before_r, seg_before_nxt;
  kce_pkg::nibble_t  held_r, held_nxt;
  logic [AW-1:0]     clr_age_r, clr_age_nxt;
  logic [AW-1:0]     ok_age_r, ok_age_nxt;
  logic [1:0]        lamp_r, lamp_nxt;

  // divider
  logic                       div_busy_r;
  logic [kce_pkg::DIV_CW-1:0] div_cnt_r;
  logic [SW:0]                div_rem_r;
  logic [EW-1:0]              div_quo_r;
  logic [SW:0]                div_sh;
  logic                       div_bit;
  logic [SW:0]                div_rem_nxt;
  logic [EW-1:0]              div_quo_nxt;

  // input stage
  logic                       s1_valid_r;
  logic                       s1_kind_r;
  logic [kce_pkg::KEY_W-1:0]  s1_lines_r;

  // result register
  logic        out_valid_r;
  logic [1:0]  o_status_r, o_status_nxt;
  logic [4:0]  o_lights_r, o_lights_nxt;
  logic [1:0]  o_color_r, o_color_nxt;
  logic [15:0] o_shown_r, o_shown_nxt;
  logic [3:0]  o_correct_r, o_correct_nxt;
  logic [3:0]  o_wrong_r, o_wrong_nxt;
  logic [1:0]  o_ksound_r, o_ksound_nxt;
  logic [1:0]  o_bsound_r, o_bsound_nxt;
  logic [kce_pkg::CODE_W-1:0] o_code_r, o_code_nxt;

  logic in_fire, cfg_fire, s2_fire, advance;
  logic [SW-1:0] step_eff;

  // sample datapath
  kce_pkg::nibble_t  code_dig [CODE_DIGITS];
  logic              el_inc;
  logic [LW-1:0]     lights;
  logic [5:0]        lights_x;
  logic [1:0]        color;
  logic              clear_flash, ok_flash;
  logic              has_empty, any_filled;
  logic [SLOT_W-1:0] first_empty, last_filled, last_post;
  kce_pkg::nibble_t  scan_key, act_key;
  logic              do_act;
  logic [CODE_ACC_W_L-1:0] code_acc;
  logic [17:0]       code_tmp;

  assign cfg_fire      = cfg_beat.valid & cfg_beat.ready;
  assign cfg_beat.ready = 1'b1;
  assign advance       = !out_valid_r || out_beat.ready;
  assign s2_fire       = s1_valid_r && advance && !div_busy_r;
  assign in_beat.ready = (!s1_valid_r || s2_fire) && !div_busy_r;
  assign in_fire       = in_beat.valid & in_beat.ready;
  assign step_eff      = (step_r == '0) ? SW'(1) : step_r;

  // restoring divide step
  always_comb begin
    div_sh  = {div_rem_r[SW-1:0], div_quo_r[EW-1]};
    div_bit = (div_sh >= {1'b0, step_eff});
    div_rem_nxt = div_bit ? (div_sh - {1'b0, step_eff}) : div_sh;
    div_quo_nxt = {div_quo_r[EW-2:0], div_bit};
  end

  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      code_dig[i] = (i < 4) ? pass_r[(4 * i) % 16 +: 4] : 4'd0;
    end
  end

  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) slots_nxt[i] = slots_r[i];
    status_nxt     = status_r;
    elapsed_nxt    = elapsed_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    seg_before_nxt = seg_before_r;
    held_nxt       = held_r;
    clr_age_nxt    = clr_age_r;
    ok_age_nxt     = ok_age_r;
    lamp_nxt       = lamp_r;
    o_ksound_nxt   = kce_pkg::KS_NONE;
    o_bsound_nxt   = kce_pkg::BS_NONE;
    clear_flash    = 1'b0;
    ok_flash       = 1'b1;
    has_empty      = 1'b0;
    any_filled     = 1'b0;
    first_empty    = '0;
    last_filled    = '0;
    last_post      = '0;
    scan_key       = kce_pkg::NO_KEY;
    act_key        = held_r;
    do_act         = 1'b0;
    el_inc         = 1'b0;
    lights         = '0;
    lights_x       = '0;
    color          = kce_pkg::COLOR_GREEN;
    code_acc       = '0;
    code_tmp       = '0;
    o_shown_nxt    = 16'hFFFF;
    o_correct_nxt  = '0;
    o_wrong_nxt    = '0;

    if (s1_kind_r) begin
      for (int i = 0; i < CODE_DIGITS; i++) slots_nxt[i] = kce_pkg::EMPTY_SLOT;
      status_nxt  = kce_pkg::ST_WAIT;
      elapsed_nxt = '0;
      rem_nxt     = '0;
      q_nxt       = '0;
      held_nxt    = kce_pkg::NO_KEY;
      clr_age_nxt = '0;
      ok_age_nxt  = '0;
    end else begin
      el_inc      = (elapsed_r != '1);
      elapsed_nxt = elapsed_r + EW'(el_inc);
      if (clr_age_r != '1) clr_age_nxt = clr_age_r + AW'(1);
      if (ok_age_r != '1) ok_age_nxt = ok_age_r + AW'(1);

      // advance running quotient
      if (el_inc) begin
        if (({1'b0, rem_r} + (SW+1)'(1)) == {1'b0, step_eff}) begin
          rem_nxt = '0;
          if (q_r != LW'(BAR_SEGMENTS)) q_nxt = q_r + LW'(1);
        end else begin
          rem_nxt = rem_r + SW'(1);
        end
      end

      for (int i = 0; i < CODE_DIGITS; i++) begin
        if (slots_r[i] == kce_pkg::EMPTY_SLOT) ok_flash = 1'b0;
        else if (slots_r[i] != code_dig[i]) clear_flash = 1'b1;
      end

      lights   = LW'(BAR_SEGMENTS) - q_nxt;
      lights_x = 6'(lights);
      if (lights_x < 6'd8) color = kce_pkg::COLOR_RED;
      else if (lights_x < 6'd16) color = kce_pkg::COLOR_YELLOW;
      else color = kce_pkg::COLOR_GREEN;
      if (seg_before_r != lights && seg_before_r != '0) begin
        o_bsound_nxt = (color == kce_pkg::COLOR_RED) ? kce_pkg::BS_RED : kce_pkg::BS_NORMAL;
      end
      seg_before_nxt = lights;
      if (elapsed_nxt >= timeout_r) status_nxt = kce_pkg::ST_TIMEOUT;

      for (int i = CODE_DIGITS - 1; i >= 0; i--) begin
        if (slots_r[i] == kce_pkg::EMPTY_SLOT) begin
          has_empty   = 1'b1;
          first_empty = SLOT_W'(i);
        end
      end
      for (int i = 0; i < CODE_DIGITS; i++) begin
        if (slots_r[i] != kce_pkg::EMPTY_SLOT) begin
          any_filled  = 1'b1;
          last_filled = SLOT_W'(i);
        end
      end

      // key scan, lowest line wins
      for (int i = kce_pkg::KEY_W - 1; i >= 0; i--) begin
        if (s1_lines_r[i]) begin
          if (i < 9) scan_key = 4'(i + 1);
          else if (i == 9) scan_key = kce_pkg::KEY_ZERO;
          else if (i == 10) scan_key = kce_pkg::KEY_CLEAR;
          else scan_key = kce_pkg::KEY_OK;
        end
      end

      if (s1_lines_r != '0) begin
        held_nxt = scan_key;
      end else if (held_r != kce_pkg::NO_KEY) begin
        do_act   = 1'b1;
        held_nxt = kce_pkg::NO_KEY;
      end

      if (do_act) begin
        if (act_key < kce_pkg::DIGIT_LIM) begin
          if (has_empty) slots_nxt[first_empty] = act_key;
          last_post = (has_empty && (!any_filled || first_empty > last_filled)) ?
                      first_empty : last_filled;
          o_ksound_nxt = (code_dig[last_post] != act_key) ? kce_pkg::KS_WRONG
                                                           : kce_pkg::KS_CLICK;
        end else if (act_key == kce_pkg::KEY_CLEAR) begin
          if (any_filled) slots_nxt[last_filled] = kce_pkg::EMPTY_SLOT;
          o_ksound_nxt = kce_pkg::KS_CLEAR;
        end else if (act_key == kce_pkg::KEY_OK) begin
          if (!has_empty) status_nxt = kce_pkg::ST_COMPLETE;
        end
      end

      if (clear_flash) begin
        if (clr_age_nxt > clr_half_r) begin
          lamp_nxt[0] = ~lamp_r[0];
          clr_age_nxt = '0;
        end
      end else begin
        lamp_nxt[0] = 1'b0;
      end
      if (ok_flash) begin
        if (ok_age_nxt > ok_half_r) begin
          lamp_nxt[1] = ~lamp_r[1];
          ok_age_nxt  = '0;
        end
      end else begin
        lamp_nxt[1] = 1'b0;
      end

      for (int i = 0; i < CODE_DIGITS; i++) begin
        if (i < 4) begin
          o_shown_nxt[(4 * i) % 16 +: 4] = slots_nxt[i];
          if (slots_nxt[i] != kce_pkg::EMPTY_SLOT) begin
            if (slots_nxt[i] == code_dig[i]) o_correct_nxt[i % 4] = 1'b1;
            else o_wrong_nxt[i % 4] = 1'b1;
          end
        end
        code_tmp = 18'(code_acc) * 18'd10 +
                   ((slots_nxt[i] == kce_pkg::EMPTY_SLOT) ? 18'd0 : 18'(slots_nxt[i]));
        code_acc = (code_tmp > 18'(kce_pkg::CODE_SAT)) ? kce_pkg::CODE_SAT
                                                       : code_tmp[CODE_ACC_W_L-1:0];
      end
    end

    o_status_nxt  = status_nxt;
    o_lights_nxt  = 5'(lights);
    o_color_nxt   = color;
    o_code_nxt    = (status_nxt == kce_pkg::ST_COMPLETE) ? {1'b0, code_acc}
                                                         : kce_pkg::CODE_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r       <= kce_pkg::RST_PASSCODE;
      timeout_r    <= kce_pkg::RST_TIMEOUT;
      step_r       <= kce_pkg::RST_STEP;
      clr_half_r   <= kce_pkg::RST_HALF;
      ok_half_r    <= kce_pkg::RST_HALF;
      for (int i = 0; i < CODE_DIGITS; i++) slots_r[i] <= kce_pkg::EMPTY_SLOT;
      status_r     <= kce_pkg::ST_WAIT;
      elapsed_r    <= '0;
      rem_r        <= '0;
      q_r          <= '0;
      seg_before_r <= '0;
      held_r       <= kce_pkg::NO_KEY;
      clr_age_r    <= '0;
      ok_age_r     <= '0;
      lamp_r       <= '0;
      div_busy_r   <= 1'b0;
      div_cnt_r    <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_beat.index)
          kce_pkg::REG_PASSCODE: pass_r     <= cfg_beat.data[kce_pkg::PASS_W-1:0];
          kce_pkg::REG_TIMEOUT:  timeout_r  <= cfg_beat.data[EW-1:0];
          kce_pkg::REG_BAR_STEP: step_r     <= cfg_beat.data[SW-1:0];
          kce_pkg::REG_CLR_HALF: clr_half_r <= cfg_beat.data[kce_pkg::HALF_W-1:0];
          kce_pkg::REG_OK_HALF:  ok_half_r  <= cfg_beat.data[kce_pkg::HALF_W-1:0];
          default: ;
        endcase
      end

      // re-divide elapsed time after a new bar step
      if (cfg_fire && cfg_beat.index == kce_pkg::REG_BAR_STEP) begin
        div_busy_r <= 1'b1;
        div_cnt_r  <= '0;
      end else if (div_busy_r) begin
        div_cnt_r <= div_cnt_r + kce_pkg::DIV_CW'(1);
        if (div_cnt_r == kce_pkg::DIV_CW'(EW - 1)) begin
          div_busy_r <= 1'b0;
          rem_r      <= div_rem_nxt[SW-1:0];
          q_r        <= (div_quo_nxt >= EW'(BAR_SEGMENTS)) ? LW'(BAR_SEGMENTS)
                                                            : div_quo_nxt[LW-1:0];
        end
      end

      if (in_fire) s1_valid_r <= 1'b1;
      else if (s2_fire) s1_valid_r <= 1'b0;

      if (s2_fire) begin
        for (int i = 0; i < CODE_DIGITS; i++) slots_r[i] <= slots_nxt[i];
        status_r     <= status_nxt;
        elapsed_r    <= elapsed_nxt;
        rem_r        <= rem_nxt;
        q_r          <= q_nxt;
        seg_before_r <= seg_before_nxt;
        held_r       <= held_nxt;
        clr_age_r    <= clr_age_nxt;
        ok_age_r     <= ok_age_nxt;
        lamp_r       <= lamp_nxt;
      end

      if (s2_fire && !s1_kind_r) out_valid_r <= 1'b1;
      else if (out_beat.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_fire && cfg_beat.index == kce_pkg::REG_BAR_STEP) begin
      div_rem_r <= '0;
      div_quo_r <= elapsed_r;
    end else if (div_busy_r) begin
      div_rem_r <= div_rem_nxt;
      div_quo_r <= div_quo_nxt;
    end
    if (in_fire) begin
      s1_kind_r  <= in_beat.kind;
      s1_lines_r <= in_beat.key_lines;
    end
    if (s2_fire && !s1_kind_r) begin
      o_status_r  <= o_status_nxt;
      o_lights_r  <= o_lights_nxt;
      o_color_r   <= o_color_nxt;
      o_shown_r   <= o_shown_nxt;
      o_correct_r <= o_correct_nxt;
      o_wrong_r   <= o_wrong_nxt;
      o_ksound_r  <= o_ksound_nxt;
      o_bsound_r  <= o_bsound_nxt;
      o_code_r    <= o_code_nxt;
    end
  end

  assign out_beat.valid        = out_valid_r;
  assign out_beat.status       = o_status_r;
  assign out_beat.bar_lights   = o_lights_r;
  assign out_beat.bar_color    = o_color_r;
  assign out_beat.shown_digits = o_shown_r;
  assign out_beat.correct_mask = o_correct_r;
  assign out_beat.wrong_mask   = o_wrong_r;
  assign out_beat.clear_lamp   = lamp_r[0];
  assign out_beat.ok_lamp      = lamp_r[1];
  assign out_beat.key_sound    = o_ksound_r;
  assign out_beat.bar_sound    = o_bsound_r;
  assign out_beat.entered_code = o_code_r;

`ifndef ASSERT_OFF
  a_rem_below_step: assert property (@(posedge clk) disable iff (!rst_n)
    !div_busy_r |-> (rem_r < step_eff))
    else $error("bar remainder not below step");

  a_q_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    q_r <= LW'(BAR_SEGMENTS))
    else $error("bar quotient above segment count");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && s1_kind_r) |=> (elapsed_r == '0 && q_r == '0 && status_r == kce_pkg::ST_WAIT))
    else $error("restart left timer or status set");

  a_no_input_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy_r |-> (!s2_fire && !in_fire))
    else $error("sample taken during re-divide");
`endif

endmodule

/* dv/keypad_code_entry_controller_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the keypad code entry controller: queued beats, bursty input,
// patterned result stalls, and an in-bench model of slots, session timer, bar and lamps.
// Depends on kce_pkg, the channel interfaces in kce_if.sv and the controller itself.
module keypad_code_entry_controller_test;

  localparam int SLOTS     = 4;
  localparam int BAR_SEGS  = 24;
  localparam int BIT_ZERO  = 9;
  localparam int BIT_CLEAR = 10;
  localparam int BIT_OK    = 11;
  localparam int PHASES    = 10;
  localparam int PER_PHASE = 85;
  localparam int MAX_SHOWN = 10;
  localparam int KW        = kce_pkg::KEY_W;
  localparam int DW        = kce_pkg::CFG_DATA_W;
  localparam int CW        = kce_pkg::CODE_W;
  localparam logic [kce_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [KW-1:0] OPENING [10] = '{
    12'h800, 12'hFFF, 12'h400, 12'h400, 12'h200,
    12'h100, 12'h001, 12'h080, 12'h004, 12'h800
  };

  typedef struct packed {
    logic          kind;
    logic [KW-1:0] lines;
  } scan_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [4:0]    lights;
    logic [1:0]    color;
    logic [15:0]   digits;
    logic [3:0]    hits;
    logic [3:0]    misses;
    logic          clr_lamp;
    logic          ok_lamp;
    logic [1:0]    key_snd;
    logic [1:0]    bar_snd;
    logic [CW-1:0] code;
  } readout_t;

  logic clk = 1'b0;
  logic rst_n;

  kce_in_if  in_beat();
  kce_out_if out_beat();
  kce_cfg_if cfg_beat();

  keypad_code_entry_controller dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_beat),
    .out_beat (out_beat),
    .cfg_beat (cfg_beat)
  );

  scan_t    keypad_scans [$];
  readout_t readouts_due [$];
  int       scans_queued;
  int       mismatches;
  bit       in_taken;

  // lock registers as last written
  logic [kce_pkg::PASS_W-1:0]    code_cfg;
  logic [kce_pkg::ELAPSED_W-1:0] timeout_cfg;
  logic [kce_pkg::STEP_W-1:0]    step_cfg;
  logic [kce_pkg::HALF_W-1:0]    clr_half_cfg;
  logic [kce_pkg::HALF_W-1:0]    ok_half_cfg;

  // session state
  kce_pkg::nibble_t              slot_q [SLOTS];
  logic [1:0]                    sess_st;
  logic [kce_pkg::ELAPSED_W-1:0] elapsed;
  logic [4:0]                    seg_prev;
  kce_pkg::nibble_t              held;
  logic [kce_pkg::AGE_W-1:0]     clr_age;
  logic [kce_pkg::AGE_W-1:0]     ok_age;
  logic                          clr_lit;
  logic                          ok_lit;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void session_restart();
    int i;
    for (i = 0; i < SLOTS; i++) slot_q[i] = kce_pkg::EMPTY_SLOT;
    sess_st = kce_pkg::ST_WAIT;
    elapsed = '0;
    held    = kce_pkg::NO_KEY;
    clr_age = '0;
    ok_age  = '0;
  endfunction

  function automatic void lock_reset();
    code_cfg     = kce_pkg::RST_PASSCODE;
    timeout_cfg  = kce_pkg::RST_TIMEOUT;
    step_cfg     = kce_pkg::RST_STEP;
    clr_half_cfg = kce_pkg::RST_HALF;
    ok_half_cfg  = kce_pkg::RST_HALF;
    session_restart();
    seg_prev = '0;
    clr_lit  = 1'b0;
    ok_lit   = 1'b0;
  endfunction

  function automatic bit lock_step(input logic kind, input logic [KW-1:0] lines,
                                   output readout_t r);
    bit          clr_flash, ok_flash, full;
    int unsigned step, quo, lit, acc;
    int          i, b, pick;
    r = '0;
    if (kind) begin
      session_restart();
      return 1'b0;
    end
    if (elapsed != '1) elapsed++;
    if (clr_age != '1) clr_age++;
    if (ok_age != '1) ok_age++;

    clr_flash = 1'b0;
    ok_flash  = 1'b1;
    for (i = 0; i < SLOTS; i++) begin
      if (slot_q[i] == kce_pkg::EMPTY_SLOT) ok_flash = 1'b0;
      else if (slot_q[i] != code_cfg[4*i +: 4]) clr_flash = 1'b1;
    end

    step = (step_cfg == '0) ? 1 : step_cfg;
    quo  = elapsed / step;
    lit  = (quo >= BAR_SEGS) ? 0 : BAR_SEGS - quo;
    r.lights = lit[4:0];
    r.color  = (lit < 8) ? kce_pkg::COLOR_RED :
               (lit < 16) ? kce_pkg::COLOR_YELLOW : kce_pkg::COLOR_GREEN;
    r.bar_snd = kce_pkg::BS_NONE;
    if (seg_prev != lit[4:0] && seg_prev != '0)
      r.bar_snd = (r.color == kce_pkg::COLOR_RED) ? kce_pkg::BS_RED : kce_pkg::BS_NORMAL;
    seg_prev = lit[4:0];
    if (elapsed >= timeout_cfg) sess_st = kce_pkg::ST_TIMEOUT;

    r.key_snd = kce_pkg::KS_NONE;
    if (lines != '0) begin
      b = 0;
      while (!lines[b]) b++;
      if (b < BIT_ZERO) held = kce_pkg::nibble_t'(b + 1);
      else if (b == BIT_ZERO) held = kce_pkg::KEY_ZERO;
      else if (b == BIT_CLEAR) held = kce_pkg::KEY_CLEAR;
      else held = kce_pkg::KEY_OK;
    end else if (held != kce_pkg::NO_KEY) begin
      if (held < kce_pkg::DIGIT_LIM) begin
        pick = -1;
        for (i = 0; i < SLOTS; i++)
          if (pick < 0 && slot_q[i] == kce_pkg::EMPTY_SLOT) pick = i;
        if (pick >= 0) slot_q[pick] = held;
        pick = -1;
        for (i = SLOTS - 1; i >= 0; i--)
          if (pick < 0 && slot_q[i] != kce_pkg::EMPTY_SLOT) pick = i;
        if (pick >= 0)
          r.key_snd = (code_cfg[4*pick +: 4] != held) ? kce_pkg::KS_WRONG : kce_pkg::KS_CLICK;
      end else if (held == kce_pkg::KEY_CLEAR) begin
        pick = -1;
        for (i = SLOTS - 1; i >= 0; i--)
          if (pick < 0 && slot_q[i] != kce_pkg::EMPTY_SLOT) pick = i;
        if (pick >= 0) slot_q[pick] = kce_pkg::EMPTY_SLOT;
        r.key_snd = kce_pkg::KS_CLEAR;
      end else if (held == kce_pkg::KEY_OK) begin
        full = 1'b1;
        for (i = 0; i < SLOTS; i++)
          if (slot_q[i] == kce_pkg::EMPTY_SLOT) full = 1'b0;
        if (full) sess_st = kce_pkg::ST_COMPLETE;
      end
      held = kce_pkg::NO_KEY;
    end

    if (clr_flash) begin
      if (clr_age > clr_half_cfg) begin
        clr_lit = ~clr_lit;
        clr_age = '0;
      end
    end else begin
      clr_lit = 1'b0;
    end
    if (ok_flash) begin
      if (ok_age > ok_half_cfg) begin
        ok_lit = ~ok_lit;
        ok_age = '0;
      end
    end else begin
      ok_lit = 1'b0;
    end

    acc = 0;
    for (i = 0; i < SLOTS; i++) begin
      r.digits[4*i +: 4] = slot_q[i];
      if (slot_q[i] != kce_pkg::EMPTY_SLOT) begin
        if (slot_q[i] == code_cfg[4*i +: 4]) r.hits[i] = 1'b1;
        else r.misses[i] = 1'b1;
      end
      acc = acc * 10 + ((slot_q[i] == kce_pkg::EMPTY_SLOT) ? 0 : slot_q[i]);
      if (acc > kce_pkg::CODE_SAT) acc = kce_pkg::CODE_SAT;
    end
    r.status   = sess_st;
    r.clr_lamp = clr_lit;
    r.ok_lamp  = ok_lit;
    r.code     = (sess_st == kce_pkg::ST_COMPLETE) ? acc[CW-1:0] : kce_pkg::CODE_NONE;
    return 1'b1;
  endfunction

  function automatic string show(input readout_t r);
    return $sformatf({"st=%0d bar=%0d col=%0d dig=%h hit=%b miss=%b lamps=%b%b",
                      " key=%0d tick=%0d code=%0d"},
                     r.status, r.lights, r.color, r.digits, r.hits, r.misses, r.clr_lamp,
                     r.ok_lamp, r.key_snd, r.bar_snd, $signed(r.code));
  endfunction

  function automatic void flag(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("%0t: %s", $time, msg);
  endfunction

  // input driver: bursts of beats, random gaps between bursts
  int burst_left;
  int gap_left;

  always @(negedge clk) begin : feed
    scan_t scan;
    if (rst_n && (!in_beat.valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_beat.valid <= 1'b0;
      end else if (keypad_scans.size() != 0) begin
        scan = keypad_scans.pop_front();
        in_beat.valid     <= 1'b1;
        in_beat.kind      <= scan.kind;
        in_beat.key_lines <= scan.lines;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_beat.valid <= 1'b0;
      end
    end
  end

  // result sink: rotating ready pattern, redrawn at random when its age runs out
  always @(negedge clk) begin : drain_side
    logic [7:0] pattern;
    int         pat_age;
    if (rst_n) begin
      if (pat_age == 0) begin
        pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
        pat_age = 64;
      end
      pat_age--;
      out_beat.ready <= pattern[0];
      pattern = {pattern[0], pattern[7:1]};
    end
  end

  always @(posedge clk) begin : watch
    readout_t want, got;
    string    diff;
    in_taken = in_beat.valid && in_beat.ready;
    if (rst_n) begin
      if (in_taken) begin
        if (lock_step(in_beat.kind, in_beat.key_lines, want)) readouts_due.push_back(want);
      end
      if (out_beat.valid && out_beat.ready) begin
        got = {out_beat.status, out_beat.bar_lights, out_beat.bar_color, out_beat.shown_digits,
               out_beat.correct_mask, out_beat.wrong_mask, out_beat.clear_lamp,
               out_beat.ok_lamp, out_beat.key_sound, out_beat.bar_sound,
               out_beat.entered_code};
        if (readouts_due.size() == 0) begin
          flag($sformatf("unexpected result beat: %s", show(got)));
        end else begin
          want = readouts_due.pop_front();
          diff = "";
          if (got.status   != want.status)   diff = {diff, " status"};
          if (got.lights   != want.lights)   diff = {diff, " bar_lights"};
          if (got.color    != want.color)    diff = {diff, " bar_color"};
          if (got.digits   != want.digits)   diff = {diff, " shown_digits"};
          if (got.hits     != want.hits)     diff = {diff, " correct_mask"};
          if (got.misses   != want.misses)   diff = {diff, " wrong_mask"};
          if (got.clr_lamp != want.clr_lamp) diff = {diff, " clear_lamp"};
          if (got.ok_lamp  != want.ok_lamp)  diff = {diff, " ok_lamp"};
          if (got.key_snd  != want.key_snd)  diff = {diff, " key_sound"};
          if (got.bar_snd  != want.bar_snd)  diff = {diff, " bar_sound"};
          if (got.code     != want.code)     diff = {diff, " entered_code"};
          if (diff != "")
            flag($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
                           diff, show(want), show(got)));
        end
      end
    end
  end

  task automatic add_scan(input logic kind, input logic [KW-1:0] lines);
    keypad_scans.push_back('{kind: kind, lines: lines});
    scans_queued++;
  endtask

  task automatic tap(input kce_pkg::nibble_t key);
    int            b;
    logic [KW-1:0] one_hot;
    b = (key == kce_pkg::KEY_CLEAR) ? BIT_CLEAR : (key == kce_pkg::KEY_OK) ? BIT_OK :
        (key == kce_pkg::KEY_ZERO) ? BIT_ZERO : int'(key) - 1;
    one_hot = KW'(1) << b;
    repeat ($urandom_range(1, 3))
      add_scan(1'b0, $urandom_range(0, 1) ? one_hot :
                     (KW'($urandom) & ({KW{1'b1}} << b)) | one_hot);
    repeat ($urandom_range(1, 2)) add_scan(1'b0, '0);
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 6))
      add_scan($urandom_range(0, 15) == 0, $urandom_range(0, 1) ? KW'(0) : KW'($urandom));
  endtask

  task automatic code_session();
    int               filled, act;
    kce_pkg::nibble_t d;
    add_scan(1'b1, KW'($urandom));
    filled = 0;
    repeat ($urandom_range(2, 9)) begin
      act = $urandom_range(0, 99);
      if (act < 60) begin
        d = (filled < SLOTS && $urandom_range(0, 1)) ? code_cfg[4*filled +: 4]
                                                      : kce_pkg::nibble_t'($urandom_range(0, 9));
        if (d >= kce_pkg::DIGIT_LIM) d = kce_pkg::nibble_t'($urandom_range(0, 9));
        tap(d);
        if (filled < SLOTS) filled++;
      end else if (act < 75) begin
        tap(kce_pkg::KEY_CLEAR);
        if (filled > 0) filled--;
      end else if (act < 92) begin
        tap(kce_pkg::KEY_OK);
      end else begin
        add_noise();
      end
      repeat ($urandom_range(0, 3)) add_scan(1'b0, '0);
    end
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) add_scan(1'b0, '0);
  endtask

  task automatic write_reg(input logic [kce_pkg::CFG_IDX_W-1:0] idx, input logic [DW-1:0] val);
    @(negedge clk);
    cfg_beat.valid <= 1'b1;
    cfg_beat.index <= idx;
    cfg_beat.data  <= val;
    do @(posedge clk); while (!cfg_beat.ready);
    case (idx)
      kce_pkg::REG_PASSCODE: code_cfg     = val[kce_pkg::PASS_W-1:0];
      kce_pkg::REG_TIMEOUT:  timeout_cfg  = val[kce_pkg::ELAPSED_W-1:0];
      kce_pkg::REG_BAR_STEP: step_cfg     = val[kce_pkg::STEP_W-1:0];
      kce_pkg::REG_CLR_HALF: clr_half_cfg = val[kce_pkg::HALF_W-1:0];
      kce_pkg::REG_OK_HALF:  ok_half_cfg  = val[kce_pkg::HALF_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_beat.valid <= 1'b0;
  endtask

  task automatic settle();
    while (keypad_scans.size() != 0 || in_beat.valid || readouts_due.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_all(input logic [DW-1:0] pass, input logic [DW-1:0] tmo,
                           input logic [DW-1:0] stp, input logic [DW-1:0] ch,
                           input logic [DW-1:0] oh);
    write_reg(kce_pkg::REG_PASSCODE, pass);
    write_reg(kce_pkg::REG_TIMEOUT, tmo);
    write_reg(kce_pkg::REG_BAR_STEP, stp);
    write_reg(kce_pkg::REG_CLR_HALF, ch);
    write_reg(kce_pkg::REG_OK_HALF, oh);
  endtask

  initial begin : stimulus
    int            target, i;
    logic [DW-1:0] pass;
    in_beat.valid     = 1'b0;
    in_beat.kind      = 1'b0;
    in_beat.key_lines = '0;
    out_beat.ready    = 1'b0;
    cfg_beat.valid    = 1'b0;
    cfg_beat.index    = '0;
    cfg_beat.data     = '0;
    rst_n             = 1'b0;
    lock_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // opening run: OK on empty slots, clear down to nothing, digit on full slots,
    // OK landing on the timeout sample, then timeout winning
    write_all(24'h008A90, 24'd20, 24'd1, 24'd1, 24'd2);
    foreach (OPENING[k]) begin
      add_scan(1'b0, OPENING[k]);
      add_scan(1'b0, '0);
    end
    add_scan(1'b0, '0);
    add_scan(1'b1, '0);
    add_scan(1'b0, '0);
    settle();

    for (i = 1; i <= PHASES; i++) begin
      case (i)
        1: write_all(24'h00FFFF, 24'hFFFFFF, 24'd699050, 24'd65535, 24'd65535);
        2: write_all(24'h000000, 24'd1, 24'd1, 24'd1, 24'd1);
        3: begin
          write_all(24'h007A31, 24'd0, 24'd0, 24'd0, 24'd0);
          write_reg(REG_SPARE, DW'($urandom));
        end
        4: write_all(DW'($urandom), 24'd60000, 24'hFFFFF, 24'd3, 24'd1);
        default: begin
          pass = '0;
          repeat (SLOTS) pass = {pass[DW-5:0], 4'($urandom_range(0, 9))};
          if ($urandom_range(0, 3) == 0) pass = DW'($urandom);
          write_all(pass, ($urandom_range(0, 4) == 0) ? 24'd60000 : 24'($urandom_range(10, 120)),
                    24'($urandom_range(1, 6)), 24'($urandom_range(1, 8)),
                    24'($urandom_range(1, 8)));
        end
      endcase
      target = scans_queued + PER_PHASE;
      while (scans_queued < target) begin
        if ($urandom_range(0, 6) == 0) add_noise();
        else code_session();
      end
      settle();
    end

    if (mismatches == 0 && readouts_due.size() == 0) begin
      $display("[keypad_code_entry_controller] OK");
    end else begin
      $display("[keypad_code_entry_controller] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("[keypad_code_entry_controller] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
sv/kce_pkg.sv
sv/kce_if.sv
sv/keypad_code_entry_controller.sv
dv/keypad_code_entry_controller_test.sv
